// ===== sv/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ===== sv/dkpt_pkg.sv =====
package dkpt_pkg;
	localparam int CAPACITY = 32;
	localparam int MAX_RESULTS = 32;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = 40;
	localparam int RW = 17 + AW;

	typedef enum logic [3:0] {
		REQ_ADD       = 4'd0,
		REQ_POP_PRIO  = 4'd1,
		REQ_POP_TIME  = 4'd2,
		REQ_PEEK_PRIO = 4'd3,
		REQ_PEEK_TIME = 4'd4,
		REQ_CHG_PRIO  = 4'd5,
		REQ_CHG_TIME  = 4'd6,
		REQ_LIST_PRIO = 4'd7,
		REQ_LIST_TIME = 4'd8
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOKEY = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_EMIT
	} state_t;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] MAXR_C = CW'(MAX_RESULTS < CAPACITY ? MAX_RESULTS : CAPACITY);
endpackage

// ===== sv/dual_key_process_table_top.sv =====
// Process table of up to 32 entries (priority, arrival time, tag), served by
// highest priority or earliest arrival, ties to the earlier insertion. Add
// needs no scan; pop, peek and change scan the stored entries, a pop then
// compacting the table behind the removed entry. A list makes one full scan
// per result. The scans are bounded by the single read port of the entry
// memory, which reads one entry per cycle.
module dual_key_process_table_top import dkpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  req_type,
	input  logic [6:0]  prio_key,
	input  logic [4:0]  key_hours,
	input  logic [5:0]  key_minutes,
	input  logic [5:0]  key_seconds,
	input  logic [15:0] entry_tag,
	input  logic [6:0]  new_prio,
	input  logic [4:0]  new_hours,
	input  logic [5:0]  new_minutes,
	input  logic [5:0]  new_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [6:0]  out_prio,
	output logic [4:0]  out_hours,
	output logic [5:0]  out_minutes,
	output logic [5:0]  out_seconds,
	output logic [15:0] out_tag,
	output logic        last
);
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;

	dkpt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .prio_key, .key_hours,
		.key_minutes, .key_seconds, .entry_tag, .new_prio, .new_hours,
		.new_minutes, .new_seconds, .out_valid, .out_stall, .status, .out_prio,
		.out_hours, .out_minutes, .out_seconds, .out_tag, .last,
		.mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
	);

	dkpt_ram #(.W(EW), .D(CAPACITY)) u_ram (
		.clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);
endmodule

// ===== sv/dkpt_ram.sv =====
module dkpt_ram #(
	parameter int W = 40,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/dkpt_ctrl.sv =====
module dkpt_ctrl import dkpt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [3:0]    req_type,
	input  logic [6:0]    prio_key,
	input  logic [4:0]    key_hours,
	input  logic [5:0]    key_minutes,
	input  logic [5:0]    key_seconds,
	input  logic [15:0]   entry_tag,
	input  logic [6:0]    new_prio,
	input  logic [4:0]    new_hours,
	input  logic [5:0]    new_minutes,
	input  logic [5:0]    new_seconds,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic [6:0]    out_prio,
	output logic [4:0]    out_hours,
	output logic [5:0]    out_minutes,
	output logic [5:0]    out_seconds,
	output logic [15:0]   out_tag,
	output logic          last,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [EW-1:0] mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [EW-1:0] mem_rdata
);
	state_t state_q, state_nx;
	req_t req_q;
	logic [6:0] pk_q, np_q;
	logic [16:0] kt_q, nt_q;
	logic [CW-1:0] count_q, iss_q, emit_q;
	logic v_s1;
	logic [AW-1:0] idx_s1;
	logic found_q, has_last_q;
	logic [RW-1:0] best_rank_q, last_rank_q;
	logic [AW-1:0] best_idx_q;
	logic [EW-1:0] best_q;
	status_t res_status_q;
	logic [EW-1:0] res_data_q;
	logic res_last_q;

	logic accept, out_free, by_time, is_pick, is_chg, is_list, scan_done, match, cand;
	logic [RW-1:0] rank;
	logic [EW-1:0] chg_data;
	logic [CW-1:0] lim;

	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign by_time = req_q inside {REQ_POP_TIME, REQ_PEEK_TIME, REQ_LIST_TIME};
	assign is_pick = req_q inside {REQ_POP_PRIO, REQ_POP_TIME, REQ_PEEK_PRIO, REQ_PEEK_TIME};
	assign is_chg = req_q inside {REQ_CHG_PRIO, REQ_CHG_TIME};
	assign is_list = req_q inside {REQ_LIST_PRIO, REQ_LIST_TIME};
	assign scan_done = (iss_q == count_q) && !v_s1;
	assign lim = (count_q < MAXR_C) ? count_q : MAXR_C;
	assign rank = by_time ? {mem_rdata[32:16], idx_s1} : {10'd0, ~mem_rdata[39:33], idx_s1};
	assign match = (req_q == REQ_CHG_PRIO) ? (mem_rdata[39:33] == pk_q)
		: (mem_rdata[32:16] == kt_q);
	assign chg_data = (req_q == REQ_CHG_PRIO) ? {np_q, mem_rdata[32:0]}
		: {mem_rdata[39:33], nt_q, mem_rdata[15:0]};
	assign cand = (!has_last_q || rank > last_rank_q) && (!found_q || rank < best_rank_q);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req_type <= 4'(REQ_LIST_TIME)) begin
					if (req_type == 4'(REQ_ADD) || count_q == '0) begin
						state_nx = S_EMIT;
					end else begin
						state_nx = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					if (is_pick && (req_q == REQ_POP_PRIO || req_q == REQ_POP_TIME)) begin
						state_nx = S_SHIFT;
					end else begin
						state_nx = S_EMIT;
					end
				end
			end
			S_SHIFT: begin
				if (scan_done) begin
					state_nx = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_nx = res_last_q ? S_IDLE : S_SCAN;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != S_IDLE);
		mem_we = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = {prio_key, key_hours, key_minutes, key_seconds, entry_tag};
		mem_raddr = iss_q[AW-1:0];
		case (state_q)
			S_IDLE: mem_we = accept && req_type == 4'(REQ_ADD) && count_q != CAP_C;
			S_SCAN: begin
				if (scan_done && is_chg && found_q) begin
					mem_we = 1'b1;
					mem_waddr = best_idx_q;
					mem_wdata = best_q;
				end
			end
			S_SHIFT: begin
				mem_we = v_s1;
				mem_waddr = idx_s1 - AW'(1);
				mem_wdata = mem_rdata;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
			iss_q <= '0;
			emit_q <= '0;
			found_q <= 1'b0;
			has_last_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_valid && !out_stall && state_q != S_EMIT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= req_t'(req_type);
						pk_q <= prio_key;
						kt_q <= {key_hours, key_minutes, key_seconds};
						np_q <= new_prio;
						nt_q <= {new_hours, new_minutes, new_seconds};
						iss_q <= '0;
						emit_q <= '0;
						found_q <= 1'b0;
						has_last_q <= 1'b0;
						res_data_q <= '0;
						res_last_q <= 1'b1;
						if (req_type == 4'(REQ_ADD)) begin
							if (count_q == CAP_C) begin
								res_status_q <= ST_FULL;
							end else begin
								res_status_q <= ST_OK;
								count_q <= count_q + CW'(1);
							end
						end else begin
							res_status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
						end
					end
				end
				S_SCAN, S_SHIFT: begin
					if (!scan_done) begin
						v_s1 <= (iss_q != count_q);
						idx_s1 <= iss_q[AW-1:0];
						if (iss_q != count_q) begin
							iss_q <= iss_q + CW'(1);
						end
					end
					if (state_q == S_SCAN && v_s1) begin
						if (is_chg) begin
							if (!found_q && match) begin
								found_q <= 1'b1;
								best_idx_q <= idx_s1;
								best_q <= chg_data;
							end
						end else if (cand) begin
							found_q <= 1'b1;
							best_rank_q <= rank;
							best_idx_q <= idx_s1;
							best_q <= mem_rdata;
						end
					end
					if (state_q == S_SCAN && scan_done) begin
						v_s1 <= 1'b0;
						iss_q <= CW'(best_idx_q) + CW'(1);
						res_status_q <= (is_chg && !found_q) ? ST_NOKEY : ST_OK;
						res_data_q <= (is_chg && !found_q) ? '0 : best_q;
						res_last_q <= is_list ? (emit_q + CW'(1) == lim) : 1'b1;
						last_rank_q <= best_rank_q;
						has_last_q <= 1'b1;
					end
					if (state_q == S_SHIFT && scan_done) begin
						v_s1 <= 1'b0;
						count_q <= count_q - CW'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						status <= res_status_q;
						{out_prio, out_hours, out_minutes, out_seconds, out_tag} <= res_data_q;
						last <= res_last_q;
						emit_q <= emit_q + CW'(1);
						iss_q <= '0;
						found_q <= 1'b0;
					end
				end
				default: v_s1 <= 1'b0;
			endcase
		end
	end
endmodule

// ===== sv/dkpt_checker.sv =====
`include "assert_macros.svh"
module dkpt_checker import dkpt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [6:0]  out_prio,
	input logic [15:0] out_tag,
	input logic        last
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_IMPL(a_err_last, clk, arst_n, out_valid && status != ST_OK, last)
	`ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && status != ST_OK, out_prio == 7'd0 && out_tag == 16'd0)
	`ASSERT_IMPL(a_list_ok, clk, arst_n, out_valid && !last, status == ST_OK)
endmodule

bind dual_key_process_table_top dkpt_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .status, .out_prio, .out_tag, .last
);

// ===== test/tb_dual_key_process_table_top.sv =====
`timescale 1ns / 100ps

module tb_dual_key_process_table_top;
	import dkpt_pkg::*;

	typedef struct packed {
		logic [6:0]  prio;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic [1:0] st;
		entry_t     ent;
		logic       fin;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  req_type = '0;
	logic [6:0]  prio_key = '0;
	logic [4:0]  key_hours = '0;
	logic [5:0]  key_minutes = '0;
	logic [5:0]  key_seconds = '0;
	logic [15:0] entry_tag = '0;
	logic [6:0]  new_prio = '0;
	logic [4:0]  new_hours = '0;
	logic [5:0]  new_minutes = '0;
	logic [5:0]  new_seconds = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [6:0]  out_prio;
	logic [4:0]  out_hours;
	logic [5:0]  out_minutes;
	logic [5:0]  out_seconds;
	logic [15:0] out_tag;
	logic        last;

	entry_t  table_q[$];
	answer_t answers_q[$];
	int      errors = 0;
	int      burst_left = 0;
	int      stall_mode = 0;

	always #6 clk = ~clk;

	dual_key_process_table_top dut (.*);

	function automatic logic [16:0] time_of(entry_t e);
		return {e.hours, e.minutes, e.seconds};
	endfunction

	function automatic answer_t mk(logic [1:0] st, entry_t e, logic fin);
		answer_t a;
		a.st = st;
		a.ent = e;
		a.fin = fin;
		return a;
	endfunction

	task automatic predict_table(logic [3:0] rq, entry_t k, entry_t nv);
		int best;
		entry_t e;
		entry_t sorted[$];
		int j;
		int lim;
		if (rq > REQ_LIST_TIME)
			return;
		if (rq == REQ_ADD) begin
			if (table_q.size() >= CAPACITY) begin
				answers_q.push_back(mk(ST_FULL, '0, 1'b1));
			end else begin
				table_q.push_back(k);
				answers_q.push_back(mk(ST_OK, '0, 1'b1));
			end
			return;
		end
		if (table_q.size() == 0) begin
			answers_q.push_back(mk(ST_EMPTY, '0, 1'b1));
			return;
		end
		if (rq <= REQ_PEEK_TIME) begin
			best = 0;
			for (int i = 1; i < table_q.size(); i++)
				if (rq == REQ_POP_TIME || rq == REQ_PEEK_TIME) begin
					if (time_of(table_q[i]) < time_of(table_q[best]))
						best = i;
				end else if (table_q[i].prio > table_q[best].prio) begin
					best = i;
				end
			e = table_q[best];
			if (rq <= REQ_POP_TIME)
				table_q.delete(best);
			answers_q.push_back(mk(ST_OK, e, 1'b1));
			return;
		end
		if (rq == REQ_CHG_PRIO || rq == REQ_CHG_TIME) begin
			foreach (table_q[i]) begin
				if (rq == REQ_CHG_PRIO && table_q[i].prio == k.prio) begin
					table_q[i].prio = nv.prio;
					answers_q.push_back(mk(ST_OK, table_q[i], 1'b1));
					return;
				end
				if (rq == REQ_CHG_TIME && time_of(table_q[i]) == time_of(k)) begin
					table_q[i].hours = nv.hours;
					table_q[i].minutes = nv.minutes;
					table_q[i].seconds = nv.seconds;
					answers_q.push_back(mk(ST_OK, table_q[i], 1'b1));
					return;
				end
			end
			answers_q.push_back(mk(ST_NOKEY, '0, 1'b1));
			return;
		end
		foreach (table_q[i]) begin
			e = table_q[i];
			j = sorted.size();
			while (j > 0 && ((rq == REQ_LIST_TIME) ? time_of(sorted[j-1]) > time_of(e)
					: sorted[j-1].prio < e.prio))
				j--;
			sorted.insert(j, e);
		end
		lim = sorted.size() < MAX_RESULTS ? sorted.size() : MAX_RESULTS;
		for (int i = 0; i < lim; i++)
			answers_q.push_back(mk(ST_OK, sorted[i], i == lim - 1));
	endtask

	task automatic report_mismatch(string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic send_request(logic [3:0] rq, entry_t k, entry_t nv);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		prio_key <= k.prio;
		key_hours <= k.hours;
		key_minutes <= k.minutes;
		key_seconds <= k.seconds;
		entry_tag <= k.tag;
		new_prio <= nv.prio;
		new_hours <= nv.hours;
		new_minutes <= nv.minutes;
		new_seconds <= nv.seconds;
		do @(posedge clk); while (in_stall);
		predict_table(rq, k, nv);
		@(negedge clk);
	endtask

	function automatic entry_t rand_entry();
		entry_t e;
		e.prio = 7'($urandom_range(0, 99));
		e.hours = 5'($urandom_range(0, 23));
		e.minutes = 6'($urandom_range(0, 59));
		e.seconds = 6'($urandom_range(0, 59));
		e.tag = 16'($urandom);
		return e;
	endfunction

	function automatic entry_t small_entry();
		entry_t e;
		e = rand_entry();
		e.prio = 7'($urandom_range(0, 3) * 33);
		e.hours = 5'($urandom_range(0, 1) * 23);
		e.minutes = 6'($urandom_range(0, 1) * 59);
		e.seconds = 6'($urandom_range(0, 1) * 59);
		return e;
	endfunction

	task automatic drain_results();
		in_valid <= 1'b0;
		while (answers_q.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	always @(posedge clk) begin
		answer_t a;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_q.size() == 0) begin
				report_mismatch("unexpected result");
			end else begin
				a = answers_q.pop_front();
				if (status !== a.st)
					report_mismatch($sformatf("status %0d exp %0d", status, a.st));
				if ({out_prio, out_hours, out_minutes, out_seconds, out_tag} !== a.ent)
					report_mismatch($sformatf("entry %h exp %h",
						{out_prio, out_hours, out_minutes, out_seconds, out_tag}, a.ent));
				if (last !== a.fin)
					report_mismatch($sformatf("last %b exp %b", last, a.fin));
			end
		end
	end

	always @(negedge clk) begin
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				out_stall <= ($urandom_range(0, 1) == 0);
			end
		endcase
		if ($urandom_range(0, 60) == 0)
			stall_mode = $urandom_range(0, 2);
	end

	task automatic test_empty_table();
		entry_t z;
		z = '0;
		for (int r = REQ_POP_PRIO; r <= REQ_LIST_TIME; r++)
			send_request(4'(r), z, z);
		send_request(4'd9, z, z);
		send_request(4'd15, z, z);
	endtask

	task automatic test_extremes();
		entry_t a;
		entry_t b;
		a = '0;
		b = '1;
		b.prio = 7'd127;
		send_request(REQ_ADD, a, a);
		send_request(REQ_ADD, b, b);
		send_request(REQ_ADD, a, b);
		send_request(REQ_PEEK_PRIO, a, a);
		send_request(REQ_PEEK_TIME, a, a);
		send_request(REQ_CHG_PRIO, b, a);
		send_request(REQ_CHG_TIME, a, b);
		send_request(REQ_CHG_PRIO, rand_entry(), a);
		send_request(REQ_LIST_PRIO, a, a);
		send_request(REQ_LIST_TIME, a, a);
		send_request(REQ_POP_PRIO, a, a);
		send_request(REQ_POP_TIME, a, a);
		send_request(REQ_POP_TIME, a, a);
		drain_results();
	endtask

	task automatic test_full_table();
		while (table_q.size() < CAPACITY)
			send_request(REQ_ADD, small_entry(), '0);
		send_request(REQ_ADD, rand_entry(), '0);
		send_request(REQ_LIST_PRIO, '0, '0);
		send_request(REQ_LIST_TIME, '0, '0);
		drain_results();
		while (table_q.size() > 0)
			send_request(4'($urandom_range(1, 2)), '0, '0);
	endtask

	task automatic test_random_mix();
		entry_t k;
		entry_t nv;
		logic [3:0] rq;
		int pick;
		for (int n = 0; n < 120; n++) begin
			pick = $urandom_range(0, 99);
			k = ($urandom_range(0, 1) == 0) ? small_entry() : rand_entry();
			nv = rand_entry();
			if (pick < 35)
				rq = REQ_ADD;
			else if (pick < 85)
				rq = 4'($urandom_range(1, 6));
			else if (pick < 93)
				rq = 4'($urandom_range(7, 8));
			else if (pick < 96)
				rq = 4'($urandom_range(9, 15));
			else begin
				rq = 4'($urandom_range(0, 8));
				k = entry_t'(40'({$urandom, $urandom}));
				nv = entry_t'(40'({$urandom, $urandom}));
			end
			if ((rq == REQ_CHG_PRIO || rq == REQ_CHG_TIME) && table_q.size() != 0
					&& $urandom_range(0, 2) != 0)
				k = table_q[$urandom_range(0, table_q.size() - 1)];
			send_request(rq, k, nv);
			if (n == 60)
				drain_results();
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_table();
		test_extremes();
		test_full_table();
		test_random_mix();
		drain_results();
		if (errors == 0)
			$display("dual_key_process_table_top regression: pass");
		else
			$display("dual_key_process_table_top regression: fail");
		$finish;
	end

	initial begin
		#30ms;
		$display("dual_key_process_table_top regression: fail");
		$finish;
	end
endmodule
